>>> hw/rtl/jms_pkg.sv
// shared types and constants of the jpeg marker scanner
package jms_pkg;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_AFTERFF = 3'd1,
    PH_LENHI   = 3'd2,
    PH_LENLO   = 3'd3,
    PH_SKIP    = 3'd4,
    PH_STOP    = 3'd5
  } phase_t;

  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_00  = 8'h00;
  localparam logic [7:0] MK_TEM   = 8'h01;
  localparam logic [7:0] MK_SOS   = 8'hDA;
  localparam logic [3:0] MK_RST_HI = 4'hD;
  localparam logic [3:0] MK_EOI_LO = 4'h9;
  localparam logic [15:0] LEN_FIELD_BYTES = 16'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_EOF    = 2'd1;
  localparam logic [1:0] STATUS_BADLEN = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
    logic       file_end;
    logic       is_ff;
    logic       is_zero;
    logic       is_standalone;
  } item_t;

endpackage

>>> hw/rtl/jms_if.sv
// word channels of the jpeg marker scanner
interface jms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;
  logic       file_end;

  modport source (output valid, data_byte, file_start, file_end, input ready);
  modport sink (input valid, data_byte, file_start, file_end, output ready);
endinterface

interface jms_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  marker_code;
  logic [15:0] payload_length;
  logic        has_length;
  logic        scan_start;
  logic [1:0]  status;

  modport source (output valid, marker_code, payload_length, has_length, scan_start,
                  status, input ready);
  modport sink (input valid, marker_code, payload_length, has_length, scan_start,
                status, output ready);
endinterface

>>> hw/rtl/jms_front.sv
// input stage: takes a byte word and classifies it
module jms_front (
  input  logic           clk,
  input  logic           rst_n,
  jms_in_if.sink         in_chan,
  output logic           push_valid,
  output jms_pkg::item_t push_item,
  input  logic           push_ready
);

  logic           valid_r;
  jms_pkg::item_t item_r;
  jms_pkg::item_t item_nxt;
  logic           take;

  assign in_chan.ready = !valid_r || push_ready;
  assign take          = in_chan.ready;

  always_comb begin
    item_nxt.data_byte     = in_chan.data_byte;
    item_nxt.file_start    = in_chan.file_start;
    item_nxt.file_end      = in_chan.file_end;
    item_nxt.is_ff         = in_chan.data_byte == jms_pkg::BYTE_FF;
    item_nxt.is_zero       = in_chan.data_byte == jms_pkg::BYTE_00;
    item_nxt.is_standalone = (in_chan.data_byte == jms_pkg::MK_TEM) ||
                             ((in_chan.data_byte[7:4] == jms_pkg::MK_RST_HI) &&
                              (in_chan.data_byte[3:0] <= jms_pkg::MK_EOI_LO));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_chan.valid) begin
      item_r <= item_nxt;
    end
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule

>>> hw/rtl/jms_fifo.sv
// short queue between the classifier and the scanner
module jms_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  jms_pkg::item_t push_item,
  output logic           push_ready,
  output logic           pop_valid,
  output jms_pkg::item_t pop_item,
  input  logic           pop_ready
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  jms_pkg::item_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            push;
  logic            pop;

  assign push_ready = count_r != CntW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hw/rtl/jms_back.sv
// scanner state machine and result register
module jms_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  input  jms_pkg::item_t pop_item,
  output logic           pop_ready,
  jms_out_if.source      out_chan
);

  jms_pkg::phase_t phase_r, phase_nxt, phase_cur, phase_step;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  lenhi_r, lenhi_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [15:0] plen;
  logic        len_short;
  logic        step;

  logic        res_valid;
  logic [7:0]  res_code;
  logic [15:0] res_plen;
  logic        res_haslen;
  logic        res_sos;
  logic [1:0]  res_status;

  logic        out_valid_r;
  logic [7:0]  out_code_r;
  logic [15:0] out_plen_r;
  logic        out_haslen_r;
  logic        out_sos_r;
  logic [1:0]  out_status_r;

  assign pop_ready = !out_valid_r || out_chan.ready;
  assign step      = pop_valid && pop_ready;
  assign plen      = {lenhi_r, pop_item.data_byte} - jms_pkg::LEN_FIELD_BYTES;
  assign len_short = (lenhi_r == 8'd0) && (pop_item.data_byte[7:1] == 7'd0);
  assign phase_cur = pop_item.file_start ? jms_pkg::PH_HUNT : phase_r;

  // next state
  always_comb begin
    phase_step = phase_cur;
    held_nxt   = held_r;
    lenhi_nxt  = lenhi_r;
    skip_nxt   = skip_r;
    unique case (phase_cur)
      jms_pkg::PH_HUNT: begin
        if (pop_item.is_ff) phase_step = jms_pkg::PH_AFTERFF;
      end
      jms_pkg::PH_AFTERFF: begin
        if (pop_item.is_ff) begin
          phase_step = jms_pkg::PH_AFTERFF;
        end else if (pop_item.is_zero || pop_item.is_standalone) begin
          phase_step = jms_pkg::PH_HUNT;
        end else begin
          held_nxt   = pop_item.data_byte;
          phase_step = jms_pkg::PH_LENHI;
        end
      end
      jms_pkg::PH_LENHI: begin
        lenhi_nxt  = pop_item.data_byte;
        phase_step = jms_pkg::PH_LENLO;
      end
      jms_pkg::PH_LENLO: begin
        if (len_short || held_r == jms_pkg::MK_SOS) begin
          phase_step = jms_pkg::PH_STOP;
        end else if (plen == 16'd0) begin
          phase_step = jms_pkg::PH_HUNT;
        end else begin
          skip_nxt   = plen;
          phase_step = jms_pkg::PH_SKIP;
        end
      end
      jms_pkg::PH_SKIP: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_r == 16'd1) phase_step = jms_pkg::PH_HUNT;
      end
      default: phase_step = jms_pkg::PH_STOP;
    endcase
    phase_nxt = (pop_item.file_end && phase_step != jms_pkg::PH_STOP) ?
                jms_pkg::PH_STOP : phase_step;
  end

  // result
  always_comb begin
    res_valid  = 1'b0;
    res_code   = 8'd0;
    res_plen   = 16'd0;
    res_haslen = 1'b0;
    res_sos    = 1'b0;
    res_status = jms_pkg::STATUS_OK;
    unique case (phase_cur)
      jms_pkg::PH_AFTERFF: begin
        if (pop_item.is_standalone) begin
          res_valid = 1'b1;
          res_code  = pop_item.data_byte;
        end
      end
      jms_pkg::PH_LENLO: begin
        res_valid  = 1'b1;
        res_code   = held_r;
        res_haslen = 1'b1;
        if (len_short) begin
          res_status = jms_pkg::STATUS_BADLEN;
        end else begin
          res_plen = plen;
          res_sos  = held_r == jms_pkg::MK_SOS;
        end
      end
      default: res_valid = 1'b0;
    endcase
    if (pop_item.file_end && phase_step != jms_pkg::PH_STOP) begin
      res_valid  = 1'b1;
      res_code   = 8'd0;
      res_plen   = 16'd0;
      res_haslen = 1'b0;
      res_sos    = 1'b0;
      res_status = jms_pkg::STATUS_EOF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= jms_pkg::PH_HUNT;
      held_r      <= 8'd0;
      lenhi_r     <= 8'd0;
      skip_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r     <= phase_nxt;
        held_r      <= held_nxt;
        lenhi_r     <= lenhi_nxt;
        skip_r      <= skip_nxt;
        out_valid_r <= res_valid;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_code_r   <= res_code;
      out_plen_r   <= res_plen;
      out_haslen_r <= res_haslen;
      out_sos_r    <= res_sos;
      out_status_r <= res_status;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.marker_code    = out_code_r;
  assign out_chan.payload_length = out_plen_r;
  assign out_chan.has_length     = out_haslen_r;
  assign out_chan.scan_start     = out_sos_r;
  assign out_chan.status         = out_status_r;

endmodule

>>> hw/rtl/jpeg_marker_scanner_core.sv
// top level of the jpeg marker scanner
// path: a taken byte word is registered in the classifier, written into the queue,
// then stepped by the scanner into the result register
// throughput: one byte word per cycle while out_chan.ready does not hold back the result register
// reset: synchronous active-low rst_n empties the queue and returns to hunting
module jpeg_marker_scanner_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  jms_in_if.sink    in_chan,
  jms_out_if.source out_chan
);

  logic           push_valid;
  logic           push_ready;
  jms_pkg::item_t push_item;
  logic           pop_valid;
  logic           pop_ready;
  jms_pkg::item_t pop_item;

  jms_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  jms_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  jms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_chan  (out_chan)
  );

endmodule

>>> dv/tb.sv
// testbench of the jpeg marker scanner: directed and random files against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] MK_SOI = 8'hD8;
  localparam logic [7:0] MK_EOI = 8'hD9;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } byte_word_t;

  typedef struct packed {
    logic [7:0]  marker_code;
    logic [15:0] payload_length;
    logic        has_length;
    logic        scan_start;
    logic [1:0]  status;
  } marker_report_t;

  logic clk = 1'b0;
  logic rst_n;

  jms_in_if  in_chan ();
  jms_out_if out_chan ();

  jpeg_marker_scanner_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scanner state as predicted
  jms_pkg::phase_t scan_ph = jms_pkg::PH_HUNT;
  logic [7:0]  marker_held = '0;
  logic [7:0]  len_hi = '0;
  logic [15:0] skip_cnt = '0;

  marker_report_t expected_q[$];
  byte_word_t     file_q[$];
  int errors = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic bit stands_alone(input logic [7:0] code);
    return code == jms_pkg::MK_TEM ||
           (code[7:4] == jms_pkg::MK_RST_HI && code[3:0] <= jms_pkg::MK_EOI_LO);
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic first, input logic last);
    marker_report_t r;
    logic [15:0]    seg_len;
    bit             found;
    found = 1'b0;
    r = '0;
    if (first) begin
      scan_ph = jms_pkg::PH_HUNT;
      marker_held = '0;
      len_hi = '0;
      skip_cnt = '0;
    end
    case (scan_ph)
      jms_pkg::PH_HUNT: begin
        if (b == jms_pkg::BYTE_FF) scan_ph = jms_pkg::PH_AFTERFF;
      end
      jms_pkg::PH_AFTERFF: begin
        if (b == jms_pkg::BYTE_FF) begin
          // fill byte
        end else if (b == jms_pkg::BYTE_00) begin
          scan_ph = jms_pkg::PH_HUNT;
        end else if (stands_alone(b)) begin
          r = '{b, 16'd0, 1'b0, 1'b0, jms_pkg::STATUS_OK};
          found = 1'b1;
          scan_ph = jms_pkg::PH_HUNT;
        end else begin
          marker_held = b;
          scan_ph = jms_pkg::PH_LENHI;
        end
      end
      jms_pkg::PH_LENHI: begin
        len_hi = b;
        scan_ph = jms_pkg::PH_LENLO;
      end
      jms_pkg::PH_LENLO: begin
        seg_len = {len_hi, b};
        found = 1'b1;
        if (seg_len < jms_pkg::LEN_FIELD_BYTES) begin
          r = '{marker_held, 16'd0, 1'b1, 1'b0, jms_pkg::STATUS_BADLEN};
          scan_ph = jms_pkg::PH_STOP;
        end else begin
          r = '{marker_held, seg_len - jms_pkg::LEN_FIELD_BYTES, 1'b1,
                marker_held == jms_pkg::MK_SOS, jms_pkg::STATUS_OK};
          if (marker_held == jms_pkg::MK_SOS) begin
            scan_ph = jms_pkg::PH_STOP;
          end else if (seg_len == jms_pkg::LEN_FIELD_BYTES) begin
            scan_ph = jms_pkg::PH_HUNT;
          end else begin
            skip_cnt = seg_len - jms_pkg::LEN_FIELD_BYTES;
            scan_ph = jms_pkg::PH_SKIP;
          end
        end
      end
      jms_pkg::PH_SKIP: begin
        skip_cnt = skip_cnt - 16'd1;
        if (skip_cnt == 16'd0) scan_ph = jms_pkg::PH_HUNT;
      end
      default: scan_ph = jms_pkg::PH_STOP;
    endcase
    // file end overrides the report of this byte unless the scanner has stopped
    if (last && scan_ph != jms_pkg::PH_STOP) begin
      r = '{8'd0, 16'd0, 1'b0, 1'b0, jms_pkg::STATUS_EOF};
      found = 1'b1;
      scan_ph = jms_pkg::PH_STOP;
    end
    if (found) expected_q.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_report();
    marker_report_t want;
    if (expected_q.size() == 0) begin
      $display("%0t ns: unexpected word, marker %0h status %0h", $time,
               out_chan.marker_code, out_chan.status);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    check_field("marker_code", 16'(want.marker_code), 16'(out_chan.marker_code));
    check_field("payload_length", want.payload_length, out_chan.payload_length);
    check_field("has_length", 16'(want.has_length), 16'(out_chan.has_length));
    check_field("scan_start", 16'(want.scan_start), 16'(out_chan.scan_start));
    check_field("status", 16'(want.status), 16'(out_chan.status));
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        predict_byte(in_chan.data_byte, in_chan.file_start, in_chan.file_end);
      if (out_chan.valid && out_chan.ready) check_report();
    end
  end

  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.data_byte  <= b;
    in_chan.file_start <= first;
    in_chan.file_end   <= last;
    do @(posedge clk); while (!in_chan.ready);
    bytes_sent++;
  endtask

  task automatic send_words();
    foreach (file_q[i]) send_byte(file_q[i].data, file_q[i].first, file_q[i].last);
    file_q.delete();
  endtask

  function automatic void put_byte(input logic [7:0] b);
    file_q.push_back('{b, 1'b0, 1'b0});
  endfunction

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_standalone();
    if ($urandom_range(10) == 0) return jms_pkg::MK_TEM;
    return {jms_pkg::MK_RST_HI, 4'($urandom_range(0, jms_pkg::MK_EOI_LO))};
  endfunction

  function automatic logic [7:0] random_segment_code();
    logic [7:0] mk;
    do mk = 8'($urandom_range(2, 254)); while (stands_alone(mk) || mk == jms_pkg::MK_SOS);
    return mk;
  endfunction

  function automatic logic [7:0] random_payload();
    if ($urandom_range(3) == 0) return jms_pkg::BYTE_FF;
    return 8'($urandom_range(255));
  endfunction

  task automatic test_standalone_markers();
    put_byte(jms_pkg::BYTE_FF); put_byte(MK_SOI);
    put_byte(jms_pkg::BYTE_FF); put_byte(jms_pkg::BYTE_FF); put_byte(jms_pkg::MK_TEM);
    put_byte(jms_pkg::BYTE_FF); put_byte(jms_pkg::BYTE_00);
    put_byte(jms_pkg::BYTE_FF); put_byte(8'hD7);
    put_byte(jms_pkg::BYTE_FF); put_byte(MK_EOI);
    file_q[0].first = 1'b1;
    send_words();
  endtask

  task automatic test_length_segments();
    // empty payload, then a payload holding 0xff that must be skipped
    put_byte(jms_pkg::BYTE_FF); put_byte(8'hE0); put_byte(8'h00); put_byte(8'h02);
    put_byte(jms_pkg::BYTE_FF); put_byte(8'hC4); put_byte(8'h00); put_byte(8'h03);
    put_byte(jms_pkg::BYTE_FF);
    put_byte(jms_pkg::BYTE_FF); put_byte(MK_EOI);
    file_q[0].first = 1'b1;
    file_q[file_q.size() - 1].last = 1'b1;
    send_words();
    // length below two stops the scanner, file end then has no effect
    put_byte(jms_pkg::BYTE_FF); put_byte(8'hDB); put_byte(8'h00); put_byte(8'h01);
    put_byte(jms_pkg::BYTE_00);
    file_q[0].first = 1'b1;
    file_q[file_q.size() - 1].last = 1'b1;
    send_words();
  endtask

  task automatic test_scan_start();
    put_byte(jms_pkg::BYTE_FF); put_byte(jms_pkg::MK_SOS);
    put_byte(jms_pkg::BYTE_FF); put_byte(jms_pkg::BYTE_FF);
    put_byte(MK_EOI);
    file_q[0].first = 1'b1;
    file_q[file_q.size() - 1].last = 1'b1;
    send_words();
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(4, 16);
    for (int i = 0; i < n; i++)
      file_q.push_back('{8'($urandom_range(255)), i == 0 || $urandom_range(5) == 0,
                         $urandom_range(7) == 0});
    send_words();
  endtask

  task automatic send_random_file();
    int          n_seg;
    int          cut;
    logic [15:0] seg_len;
    bit          open_end;
    open_end = 1'b0;
    put_byte(jms_pkg::BYTE_FF); put_byte(MK_SOI);
    n_seg = $urandom_range(1, 5);
    for (int i = 0; i < n_seg && !open_end; i++) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 254)));
        1: begin
          put_byte(jms_pkg::BYTE_FF); put_byte(jms_pkg::BYTE_00);
        end
        2, 3: begin
          repeat ($urandom_range(0, 2)) put_byte(jms_pkg::BYTE_FF);
          put_byte(jms_pkg::BYTE_FF); put_byte(random_standalone());
        end
        default: begin
          case ($urandom_range(19))
            0: seg_len = 16'($urandom_range(0, 65535));
            1: seg_len = 16'($urandom_range(0, 1));
            default: seg_len = 16'($urandom_range(2, 9));
          endcase
          put_byte(jms_pkg::BYTE_FF); put_byte(random_segment_code());
          put_byte(seg_len[15:8]); put_byte(seg_len[7:0]);
          // long segments are cut short by the next file
          if (seg_len < jms_pkg::LEN_FIELD_BYTES || seg_len > 16'd9) open_end = 1'b1;
          else repeat (seg_len - jms_pkg::LEN_FIELD_BYTES) put_byte(random_payload());
        end
      endcase
    end
    if (!open_end) begin
      case ($urandom_range(0, 3))
        0: begin
          put_byte(jms_pkg::BYTE_FF); put_byte(jms_pkg::MK_SOS);
          put_byte(jms_pkg::BYTE_00); put_byte(8'($urandom_range(2, 12)));
          repeat ($urandom_range(0, 4)) put_byte(random_payload());
          if ($urandom_range(1) == 0) file_q[file_q.size() - 1].last = 1'b1;
        end
        1: begin
          put_byte(jms_pkg::BYTE_FF); put_byte(MK_EOI);
          file_q[file_q.size() - 1].last = 1'b1;
        end
        2: begin
          put_byte(jms_pkg::BYTE_FF); put_byte(MK_EOI);
        end
        default: begin
          cut = $urandom_range(0, file_q.size() - 1);
          while (file_q.size() > cut + 1) void'(file_q.pop_back());
          file_q[cut].last = 1'b1;
        end
      endcase
    end
    // occasional corrupted byte
    if ($urandom_range(7) == 0)
      file_q[$urandom_range(0, file_q.size() - 1)].data = 8'($urandom_range(255));
    file_q[0].first = 1'b1;
    send_words();
  endtask

  task automatic test_random_files(input int n_bytes);
    int start_count;
    start_count = bytes_sent;
    while (bytes_sent - start_count < n_bytes) begin
      if ($urandom_range(9) == 0) send_noise();
      else send_random_file();
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.data_byte  <= '0;
    in_chan.file_start <= 1'b0;
    in_chan.file_end   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 38;
    recv_idle_pct = 81;
    test_standalone_markers();
    test_length_segments();
    test_scan_start();
    wait_drained();
    test_random_files(260);
    wait_drained();
    send_idle_pct = 81;
    recv_idle_pct = 38;
    test_random_files(260);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_files(260);
    wait_drained();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** jpeg_marker_scanner_core: PASSED **");
    end else begin
      $display("** jpeg_marker_scanner_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t ns: timeout", $time);
    $display("** jpeg_marker_scanner_core: FAILED **");
    $finish;
  end

endmodule

>>> jpeg_marker_scanner_core.f
hw/rtl/jms_pkg.sv
hw/rtl/jms_if.sv
hw/rtl/jms_front.sv
hw/rtl/jms_fifo.sv
hw/rtl/jms_back.sv
hw/rtl/jpeg_marker_scanner_core.sv
dv/tb.sv
